### rtl/wfba_pkg.sv
package wfba_pkg;

   localparam int BLOCK_COUNT_DEF = 16;
   localparam int SIZE_BITS_DEF   = 16;

   // Field widths of the channel words.
   localparam int SLOT_W   = 4;
   localparam int VALUE_W  = 16;
   localparam int BIU_W    = 5;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

   // Register index, taken from paddr above the byte offset.
   localparam logic CSR_IDX_BLOCKS_IN_USE = 1'b0;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   typedef struct packed {
      logic start;     // word accepted: latch request, clear best candidate
      logic load_wr;   // word accepted and it is a load
      logic scan_rd;   // read one block at scan_addr
      logic commit;    // write back the chosen block
      logic out_load;  // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic have;      // a fitting block has been found
   } status_type;

endpackage

### rtl/wfba_ctrl.sv
module wfba_ctrl
   import wfba_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
   localparam int IDX_W = $clog2(BLOCK_COUNT),
   localparam int CNT_W = $clog2(BLOCK_COUNT + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_opcode,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [BIU_W-1:0] blocks_in_use,
   input  status_type       stat,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] scan_addr
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] limit;
   logic             accept;
   logic             scan_last;

   always_comb begin
      if (32'(blocks_in_use) > BLOCK_COUNT) begin
         limit = CNT_W'(BLOCK_COUNT);
      end else begin
         limit = CNT_W'(blocks_in_use);
      end
   end

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign scan_last = ({1'b0, cnt_ff} + (CNT_W+1)'(1)) >= {1'b0, limit};
   assign scan_addr = IDX_W'(cnt_ff);

   always_comb begin
      cmd          = '0;
      cmd.start    = accept;
      cmd.load_wr  = accept && (req_opcode == OP_LOAD);
      cmd.scan_rd  = (state_ff == ST_SCAN) && (cnt_ff < limit);
      cmd.commit   = (state_ff == ST_COMMIT) && stat.have;
      cmd.out_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cnt_ff <= '0;
                  if (req_opcode == OP_REQUEST) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (scan_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            // The last block read is compared during this cycle.
            ST_DRAIN: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (cmd.out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/wfba_datapath.sv
module wfba_datapath
   import wfba_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
   parameter int SIZE_BITS   = SIZE_BITS_DEF,
   localparam int IDX_W = $clog2(BLOCK_COUNT)
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [IDX_W-1:0]   scan_addr,
   input  logic [SLOT_W-1:0]  req_block_slot,
   input  logic [VALUE_W-1:0] req_size_value,
   output status_type         stat,
   output logic               rsp_found,
   output logic [SLOT_W-1:0]  rsp_chosen_block,
   output logic [VALUE_W-1:0] rsp_original_size,
   output logic [VALUE_W-1:0] rsp_fragment_size
);

   logic [SIZE_BITS-1:0] remaining_mem [BLOCK_COUNT];
   logic [SIZE_BITS-1:0] loaded_mem    [BLOCK_COUNT];
   logic [BLOCK_COUNT-1:0] occupied_ff;

   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] rd_rem_ff;
   logic                 rd_occ_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 rd_vld_ff;
   logic                 have_ff;
   logic [SIZE_BITS-1:0] best_rem_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [SIZE_BITS-1:0] orig_ff;
   logic [SIZE_BITS-1:0] frag_ff;
   logic                 found_ff;
   logic [SLOT_W-1:0]    chosen_ff;
   logic [VALUE_W-1:0]   orig_out_ff;
   logic [VALUE_W-1:0]   frag_out_ff;

   logic [SIZE_BITS-1:0] size_in;
   logic [IDX_W-1:0]     slot_idx;
   logic                 slot_ok;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic [SIZE_BITS-1:0] frag_in;
   logic                 better;

   assign size_in  = SIZE_BITS'(req_size_value);
   assign slot_idx = IDX_W'(req_block_slot);
   assign slot_ok  = 32'(req_block_slot) < BLOCK_COUNT;
   assign frag_in  = best_rem_ff - size_ff;

   assign wr_en   = (cmd.load_wr && slot_ok) || cmd.commit;
   assign wr_addr = cmd.commit ? best_idx_ff : slot_idx;
   assign wr_data = cmd.commit ? frag_in : size_in;

   // A free block that fits and beats the current best; ties keep the lower index.
   assign better = rd_vld_ff && !rd_occ_ff && (rd_rem_ff >= size_ff)
                   && (!have_ff || (rd_rem_ff > best_rem_ff));

   assign stat.have = have_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         remaining_mem[wr_addr] <= wr_data;
      end
      if (cmd.load_wr && slot_ok) begin
         loaded_mem[slot_idx] <= size_in;
      end
      rd_rem_ff <= remaining_mem[scan_addr];
      orig_ff   <= loaded_mem[best_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= '0;
         rd_vld_ff   <= 1'b0;
         have_ff     <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
         if (cmd.load_wr && slot_ok) begin
            occupied_ff[slot_idx] <= 1'b0;
         end
         if (cmd.commit) begin
            occupied_ff[best_idx_ff] <= 1'b1;
         end
         if (cmd.start) begin
            have_ff <= 1'b0;
         end else if (better) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_occ_ff <= occupied_ff[scan_addr];
      rd_idx_ff <= scan_addr;
      if (cmd.start) begin
         size_ff <= size_in;
      end
      if (better) begin
         best_rem_ff <= rd_rem_ff;
         best_idx_ff <= rd_idx_ff;
      end
      if (cmd.commit) begin
         frag_ff <= frag_in;
      end
      if (cmd.out_load) begin
         found_ff    <= have_ff;
         chosen_ff   <= have_ff ? SLOT_W'(best_idx_ff) : '0;
         orig_out_ff <= have_ff ? VALUE_W'(orig_ff) : '0;
         frag_out_ff <= have_ff ? VALUE_W'(frag_ff) : '0;
      end
   end

   assign rsp_found         = found_ff;
   assign rsp_chosen_block  = chosen_ff;
   assign rsp_original_size = orig_out_ff;
   assign rsp_fragment_size = frag_out_ff;

endmodule

### rtl/worst_fit_block_allocator_core.sv
// Channel   Handshake                 Word
// req       req_valid / req_ready     opcode, block_slot, size_value
// rsp       rsp_valid / rsp_ready     found, chosen_block, original_size, fragment_size
// csr       psel/penable, pready=1    blocks_in_use at byte address 0
//
// A load goes from idle to the finish state and then into the output register.
// A request reads one block per cycle from the size memory, up to min(blocks_in_use,
// BLOCK_COUNT) blocks, then passes the drain, commit and finish states before its
// result enters the output register; the next word is taken once the core is idle
// again. A result that cannot enter a full output register holds the core. Reset
// clears the occupied marks, not the size memories, and sets blocks_in_use to 16.
module worst_fit_block_allocator_core
   import wfba_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
   parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [SLOT_W-1:0]  req_block_slot,
   input  logic [VALUE_W-1:0] req_size_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic [SLOT_W-1:0]  rsp_chosen_block,
   output logic [VALUE_W-1:0] rsp_original_size,
   output logic [VALUE_W-1:0] rsp_fragment_size,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam int IDX_W = $clog2(BLOCK_COUNT);

   logic [BIU_W-1:0] blocks_in_use_ff;
   logic             csr_hit;
   cmd_type          cmd;
   status_type       stat;
   logic [IDX_W-1:0] scan_addr;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_IDX_BLOCKS_IN_USE);
   assign csr_prdata = csr_hit ? CSR_DW'(blocks_in_use_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_in_use_ff <= BIU_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         blocks_in_use_ff <= csr_pwdata[BIU_W-1:0];
      end
   end

   wfba_ctrl #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_opcode    (req_opcode),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .blocks_in_use (blocks_in_use_ff),
      .stat          (stat),
      .cmd           (cmd),
      .scan_addr     (scan_addr)
   );

   wfba_datapath #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .SIZE_BITS   (SIZE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .scan_addr         (scan_addr),
      .req_block_slot    (req_block_slot),
      .req_size_value    (req_size_value),
      .stat              (stat),
      .rsp_found         (rsp_found),
      .rsp_chosen_block  (rsp_chosen_block),
      .rsp_original_size (rsp_original_size),
      .rsp_fragment_size (rsp_fragment_size)
   );

endmodule
